### rtl/utpn_pkg.sv
// utpn_pkg: word types and decoder interface types for the UTF-8 pinyin
// tone normaliser. No dependencies; used by every file in rtl/.
package utpn_pkg;

  // One input word: a raw byte of the text and its end-of-string mark.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  // One result word: an optional lower-case letter and the end-of-text mark.
  typedef struct packed {
    logic       has_letter;
    logic [6:0] letter_code;
    logic       end_of_text;
  } out_word_t;

  // Bytes of an unfinished multi-byte sequence, held between words.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic [1:0]      needed;
  } pend_state_t;

  // What the decoder hands back for one accepted input word.
  typedef struct packed {
    logic [1:0]  count;
    out_word_t   res1;
    out_word_t   res0;
    pend_state_t next;
  } dec_out_t;

endpackage

### rtl/utf8_pinyin_tone_normalizer_unit.sv
// utf8_pinyin_tone_normalizer_unit: top level of the UTF-8 to pinyin letter
// normaliser. Depends on utpn_pkg and utpn_decode.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_stall_o | utpn_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i | utpn_pkg::out_word_t
//
// Cycles: one input word is taken per clock while in_stall_o is low; its results are written to a
//   four-entry result queue in the same edge and shown from the next cycle.
// Each word gives zero, one or two results; the queue drains one per clock while out_stall_i is low,
//   so throughput is one word per clock unless words give two results.
// Reset clears the held partial sequence and empties the queue at once.
// in_stall_o rises when fewer than two queue entries are free; it depends on
//   registered fill only, never on out_stall_i in the same cycle.
module utf8_pinyin_tone_normalizer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  utpn_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output utpn_pkg::out_word_t out_word_o
);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);

  utpn_pkg::pend_state_t pend_q;
  utpn_pkg::pend_state_t pend_d;
  utpn_pkg::dec_out_t    dec;
  utpn_pkg::out_word_t   fifo_q [FifoDepth];

  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             in_accept;
  logic             out_accept;
  logic [1:0]       push_n;

  // Decode the incoming byte against the held partial sequence.
  utpn_decode u_decode (
    .in_word_i (in_word_i),
    .pend_i    (pend_q),
    .dec_o     (dec)
  );

  // Stall while the queue could not take a two-result word.
  assign in_stall_o  = fill_q > FillW'(FifoDepth - 2);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = fill_q != '0;
  assign out_accept  = out_valid_o && !out_stall_i;
  assign out_word_o  = fifo_q[rd_ptr_q];

  assign push_n = in_accept ? dec.count : 2'd0;

  // Advance held state only on an accepted word.
  assign pend_d   = in_accept ? dec.next : pend_q;
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + PtrW'(out_accept);
  assign fill_d   = fill_q + FillW'(push_n) - FillW'(out_accept);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      pend_q   <= pend_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage: write first result, then second at the following slot.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= dec.res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= dec.res1;
    end
  end

endmodule

### rtl/utpn_decode.sv
// utpn_decode: combinational decode of one input word against the held
// partial sequence. Gives up to two result words and the next held state.
// Depends on utpn_pkg.
module utpn_decode (
  input  utpn_pkg::in_word_t    in_word_i,
  input  utpn_pkg::pend_state_t pend_i,
  output utpn_pkg::dec_out_t    dec_o
);

  localparam logic [6:0] LtrA = 7'h61;
  localparam logic [6:0] LtrE = 7'h65;
  localparam logic [6:0] LtrI = 7'h69;
  localparam logic [6:0] LtrM = 7'h6d;
  localparam logic [6:0] LtrN = 7'h6e;
  localparam logic [6:0] LtrO = 7'h6f;
  localparam logic [6:0] LtrU = 7'h75;
  localparam logic [6:0] LtrV = 7'h76;
  localparam logic [6:0] LtrZ = 7'h7a;
  localparam logic [6:0] UprA = 7'h41;
  localparam logic [6:0] UprZ = 7'h5a;
  localparam logic [6:0] CaseGap = 7'h20;
  localparam logic [6:0] NoLetter = 7'h00;

  // Sequence length announced by a lead byte; zero for a stray byte.
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    if (!c[7]) begin
      len = 3'd1;
    end else if ((c & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Assemble a code point from a lead byte in element 0 and its tail.
  function automatic logic [20:0] decode_cp(input logic [2:0] len,
                                            input logic [3:0][7:0] bb);
    logic [20:0] cp;
    case (len)
      3'd2:    cp = {10'd0, bb[0][4:0], bb[1][5:0]};
      3'd3:    cp = {5'd0, bb[0][3:0], bb[1][5:0], bb[2][5:0]};
      3'd4:    cp = {bb[0][2:0], bb[1][5:0], bb[2][5:0], bb[3][5:0]};
      default: cp = {13'd0, bb[0]};
    endcase
    return cp;
  endfunction

  // Letter for a code point; NoLetter where none applies.
  function automatic logic [6:0] map_letter(input logic [20:0] cp);
    logic [6:0] ltr;
    ltr = NoLetter;
    if (cp[20:7] == 14'd0) begin
      if (cp[6:0] >= LtrA && cp[6:0] <= LtrZ) begin
        ltr = cp[6:0];
      end else if (cp[6:0] >= UprA && cp[6:0] <= UprZ) begin
        ltr = cp[6:0] + CaseGap;
      end
    end else begin
      case (cp)
        21'h00101, 21'h001CE, 21'h000E1, 21'h000E0,
        21'h00100, 21'h001CD, 21'h000C1, 21'h000C0: ltr = LtrA;
        21'h00113, 21'h0011B, 21'h000E9, 21'h000E8,
        21'h00112, 21'h0011A, 21'h000C9, 21'h000C8: ltr = LtrE;
        21'h0012B, 21'h001D0, 21'h000ED, 21'h000EC,
        21'h0012A, 21'h001CF, 21'h000CD, 21'h000CC: ltr = LtrI;
        21'h0014D, 21'h001D2, 21'h000F3, 21'h000F2,
        21'h0014C, 21'h001D1, 21'h000D3, 21'h000D2: ltr = LtrO;
        21'h0016B, 21'h001D4, 21'h000FA, 21'h000F9,
        21'h0016A, 21'h001D3, 21'h000DA, 21'h000D9: ltr = LtrU;
        21'h001D6, 21'h001D8, 21'h001DA, 21'h001DC, 21'h000FC,
        21'h001D5, 21'h001D7, 21'h001D9, 21'h001DB, 21'h000DC: ltr = LtrV;
        21'h00144, 21'h00148, 21'h001F9,
        21'h00143, 21'h00147, 21'h001F8: ltr = LtrN;
        21'h01E3F, 21'h01E3E: ltr = LtrM;
        default: ltr = NoLetter;
      endcase
    end
    return ltr;
  endfunction

  logic [7:0]      in_byte;
  logic [1:0]      cnt;
  logic [3:0][7:0] bb;
  logic [3:0][7:0] bb_tail;
  logic [2:0]      lead_len;
  logic [2:0]      n_bytes;
  logic [2:0]      tail_len;
  logic            hold;
  logic [6:0]      ltr_a;
  logic [6:0]      ltr_b;
  logic [6:0]      first_ltr;
  logic            last;

  assign in_byte = in_word_i.byte_value;
  assign last    = in_word_i.last_byte;
  assign cnt     = pend_i.count;

  // Line up held bytes and the new byte as one short string.
  always_comb begin
    bb[0] = (cnt == 2'd0) ? in_byte : pend_i.bytes[0];
    bb[1] = (cnt <= 2'd1) ? in_byte : pend_i.bytes[1];
    bb[2] = (cnt <= 2'd2) ? in_byte : pend_i.bytes[2];
    bb[3] = in_byte;
  end

  assign bb_tail  = {8'h00, bb[3:1]};
  assign lead_len = (cnt == 2'd0) ? seq_len(in_byte) : ({1'b0, pend_i.needed} + 3'd1);
  assign n_bytes  = {1'b0, cnt} + 3'd1;
  assign tail_len = seq_len(bb[1]);
  assign hold     = !last && (lead_len > n_bytes);

  always_comb begin
    ltr_a = NoLetter;
    ltr_b = NoLetter;
    if (lead_len == 3'd0 || hold) begin
      ltr_a = NoLetter;
    end else if (lead_len <= n_bytes) begin
      ltr_a = map_letter(decode_cp(lead_len, bb));
    end else begin
      // String ended inside a sequence: drop the lead, redecode the tail.
      if (tail_len == 3'd2 && cnt == 2'd2) begin
        ltr_a = map_letter(decode_cp(3'd2, bb_tail));
      end else begin
        if (tail_len == 3'd1) begin
          ltr_a = map_letter({13'd0, bb[1]});
        end
        if (cnt == 2'd2 && seq_len(bb[2]) == 3'd1) begin
          ltr_b = map_letter({13'd0, bb[2]});
        end
      end
    end
  end

  assign first_ltr = (ltr_a != NoLetter) ? ltr_a : ltr_b;

  always_comb begin
    dec_o.res0.has_letter  = first_ltr != NoLetter;
    dec_o.res0.letter_code = first_ltr;
    dec_o.res1.has_letter  = 1'b1;
    dec_o.res1.letter_code = ltr_b;
    if (ltr_a != NoLetter && ltr_b != NoLetter) begin
      dec_o.count            = 2'd2;
      dec_o.res0.end_of_text = 1'b0;
      dec_o.res1.end_of_text = last;
    end else begin
      dec_o.count            = (first_ltr != NoLetter || last) ? 2'd1 : 2'd0;
      dec_o.res0.end_of_text = last;
      dec_o.res1.end_of_text = 1'b0;
    end
  end

  // Next held state: append the byte while the sequence is unfinished.
  always_comb begin
    dec_o.next = '0;
    if (hold) begin
      dec_o.next.bytes  = pend_i.bytes;
      dec_o.next.count  = cnt + 2'd1;
      dec_o.next.needed = (cnt == 2'd0) ? 2'(lead_len - 3'd1) : pend_i.needed;
      case (cnt)
        2'd0:    dec_o.next.bytes[0] = in_byte;
        2'd1:    dec_o.next.bytes[1] = in_byte;
        2'd2:    dec_o.next.bytes[2] = in_byte;
        default: dec_o.next.bytes    = pend_i.bytes;
      endcase
    end
  end

endmodule

### rtl/utpn_checker.sv
// utpn_checker: port-level assertions for the normaliser top level, bound in
// below. Depends on utpn_pkg.
module utpn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input utpn_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input utpn_pkg::out_word_t out_word_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Input stall only comes from a filling queue, so results are waiting.
  a_stall_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A word without a letter is only the end marker of a string.
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.has_letter |->
      out_word_o.end_of_text && out_word_o.letter_code == 7'd0)
    else $error("letterless result is not an end marker");

  // A last byte accepted into an empty unit always gives a result next cycle.
  a_last_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o && in_word_i.last_byte |=>
      out_valid_o)
    else $error("end of string produced no result");

endmodule

bind utf8_pinyin_tone_normalizer_unit utpn_checker u_utpn_checker (.*);
